// ----- hdl/snrs_pkg.sv -----
// Shared constants, types and helpers for the strongest-neighbor row scan.
package snrs_pkg;

  localparam int INDEX_BITS = 20;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  // |entry| >= den << SAT_SHIFT exactly when the quotient needs >= VALUE_BITS bits
  localparam int SAT_SHIFT  = VALUE_BITS - 1 - FRAC_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  typedef logic [INDEX_BITS-1:0]        index_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS-1:0]        umag_t;

  typedef enum logic [1:0] {
    ACT_ALREADY = 2'd0,
    ACT_JOIN    = 2'd1,
    ACT_PAIR    = 2'd2,
    ACT_SELF    = 2'd3
  } action_t;

  typedef struct packed {
    logic   have_free;
    index_t free_col;
    logic   have_joined;
    index_t joined_group;
    logic   fault_seen;
  } best_status_t;

  // two's complement magnitude; the most negative value maps to 2^(VALUE_BITS-1)
  function automatic umag_t magnitude(value_t x);
    return x[VALUE_BITS-1] ? umag_t'(-x) : umag_t'(x);
  endfunction

endpackage

// ----- hdl/snrs_divider.sv -----
// Iterative restoring divider producing the saturated signed Q16.16 weight.
module snrs_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  snrs_pkg::value_t    dividend,
  input  snrs_pkg::umag_t     divisor,
  output logic                done,
  output snrs_pkg::value_t    quotient
);
  import snrs_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } div_state_t;

  div_state_t                    state;
  logic [CNT_BITS-1:0]           count;
  logic [VALUE_BITS:0]           rem;
  umag_t                         quo;
  umag_t                         den;
  logic                          neg;
  logic                          sat;

  umag_t                         dvd_mag;
  logic [VALUE_BITS+FRAC_BITS-1:0] num;
  logic                          sat_hit;
  logic [VALUE_BITS:0]           trial;
  logic                          fits;

  assign dvd_mag = magnitude(dividend);
  assign num     = {dvd_mag, {FRAC_BITS{1'b0}}};
  assign sat_hit = {{VALUE_BITS{1'b0}}, dvd_mag} >=
                   ({{VALUE_BITS{1'b0}}, divisor} << SAT_SHIFT);
  assign trial   = {rem[VALUE_BITS-1:0], quo[VALUE_BITS-1]};
  assign fits    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            state <= sat_hit ? D_DONE : D_RUN;
            count <= CNT_BITS'(VALUE_BITS);
          end
        end
        D_RUN: begin
          count <= count - 1'b1;
          if (count == CNT_BITS'(1)) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      den <= divisor;
      neg <= dividend[VALUE_BITS-1];
      sat <= sat_hit;
      rem <= (VALUE_BITS+1)'(num[VALUE_BITS+FRAC_BITS-1:VALUE_BITS]);
      quo <= num[VALUE_BITS-1:0];
    end else if (state == D_RUN) begin
      rem <= fits ? trial - {1'b0, den} : trial;
      quo <= {quo[VALUE_BITS-2:0], fits};
    end
  end

  assign done = (state == D_DONE);

  always_comb begin
    if (sat) begin
      quotient = neg ? value_t'({1'b1, {(VALUE_BITS-1){1'b0}}})
                     : value_t'({1'b0, {(VALUE_BITS-1){1'b1}}});
    end else begin
      quotient = neg ? value_t'(-quo) : value_t'(quo);
    end
  end

endmodule

// ----- hdl/snrs_best.sv -----
// Running best free and best aggregated neighbor of the current row.
module snrs_best (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   update,
  input  snrs_pkg::value_t       weight,
  input  snrs_pkg::index_t       col,
  input  logic                   col_agg,
  input  snrs_pkg::index_t       group,
  input  logic                   set_fault,
  input  logic                   clear,
  output snrs_pkg::best_status_t status
);
  import snrs_pkg::*;

  value_t free_weight;
  index_t free_col;
  logic   have_free;
  value_t joined_weight;
  index_t joined_col;
  index_t joined_group;
  logic   have_joined;
  logic   fault_seen;

  logic   free_win;
  logic   joined_win;

  // a first candidate needs a non-negative weight; ties go to the larger column
  assign free_win   = have_free ?
      (weight > free_weight || (weight == free_weight && col > free_col)) :
      !weight[VALUE_BITS-1];
  assign joined_win = have_joined ?
      (weight > joined_weight || (weight == joined_weight && col > joined_col)) :
      !weight[VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      free_weight   <= '0;
      free_col      <= '0;
      have_free     <= 1'b0;
      joined_weight <= '0;
      joined_col    <= '0;
      joined_group  <= '0;
      have_joined   <= 1'b0;
      fault_seen    <= 1'b0;
    end else begin
      if (set_fault) begin
        fault_seen <= 1'b1;
      end
      if (update && !col_agg && free_win) begin
        free_weight <= weight;
        free_col    <= col;
        have_free   <= 1'b1;
      end
      if (update && col_agg && joined_win) begin
        joined_weight <= weight;
        joined_col    <= col;
        joined_group  <= group;
        have_joined   <= 1'b1;
      end
    end
  end

  assign status = '{have_free:    have_free,
                    free_col:     free_col,
                    have_joined:  have_joined,
                    joined_group: joined_group,
                    fault_seen:   fault_seen};

endmodule

// ----- hdl/strongest_neighbor_row_scan_core.sv -----
// Strongest-neighbor row scan: top level with item sequencer and result register.
//
// Input channel (in_valid / in_stall): one transaction per nonzero of a sparse
// matrix row, with its diagonals and the column's aggregate status. Items with
// entry_valid low carry no entry; row_last marks the final item of the row.
// Output channel (out_valid / out_stall): one decision transaction per row,
// produced for the item that has row_last set.
// Flow: an off-diagonal entry of an unaggregated row with a nonzero divisor
// runs through the shared radix-2 divider, one quotient bit per cycle; an
// entry whose weight saturates leaves the divider without the bit loop, and
// any other item bypasses the divider.
// The block takes one item at a time; in_stall is high from acceptance until
// the item has been folded into the running bests (and, for the last item,
// until the decision has been written into the output register).
// The output register holds one decision; the block keeps scanning the next
// row while it waits, and stalls only if a second decision is ready before the
// first is taken. A stalled output keeps its payload unchanged.
// Reset (rst, synchronous) empties the output register, returns the sequencer
// to idle and clears the running bests and the fault flag.
module strongest_neighbor_row_scan_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [snrs_pkg::INDEX_BITS-1:0] row_index,
  input  logic [snrs_pkg::INDEX_BITS-1:0] col_index,
  input  logic signed [snrs_pkg::VALUE_BITS-1:0] entry_value,
  input  logic signed [snrs_pkg::VALUE_BITS-1:0] diag_row,
  input  logic signed [snrs_pkg::VALUE_BITS-1:0] diag_col,
  input  logic                            row_aggregated,
  input  logic                            col_aggregated,
  input  logic [snrs_pkg::INDEX_BITS-1:0] col_group,
  input  logic                            entry_valid,
  input  logic                            row_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [snrs_pkg::INDEX_BITS-1:0] out_row,
  output logic [1:0]                      action,
  output logic [snrs_pkg::INDEX_BITS-1:0] target,
  output logic                            divide_fault
);
  import snrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_DIV    = 4'b0100,
    S_FINISH = 4'b1000
  } seq_state_t;

  seq_state_t   state;

  // captured transaction
  index_t       row;
  index_t       col;
  value_t       entry;
  umag_t        den;
  logic         row_agg;
  logic         col_agg;
  index_t       group;
  logic         ent_valid;
  logic         last;

  logic         in_take;
  logic         need_div;
  logic         div_start;
  logic         div_done;
  value_t       div_weight;
  logic         set_fault;
  logic         emit;
  best_status_t best;
  action_t      act_next;
  index_t       target_next;
  umag_t        mag_r;
  umag_t        mag_c;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // divisor is the larger absolute diagonal, formed as the item is captured
  assign mag_r = magnitude(diag_row);
  assign mag_c = magnitude(diag_col);

  always_ff @(posedge clk) begin
    if (in_take) begin
      row       <= row_index;
      col       <= col_index;
      entry     <= entry_value;
      den       <= (mag_r > mag_c) ? mag_r : mag_c;
      row_agg   <= row_aggregated;
      col_agg   <= col_aggregated;
      group     <= col_group;
      ent_valid <= entry_valid;
      last      <= row_last;
    end
  end

  // diagonal entries, empty items and aggregated rows skip the weight
  assign need_div  = ent_valid && !row_agg && (col != row);
  assign div_start = (state == S_CHECK) && need_div && (den != '0);
  assign set_fault = (state == S_CHECK) && need_div && (den == '0);
  // decision leaves when the output register is empty or being drained
  assign emit      = (state == S_FINISH) && last && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= div_start ? S_DIV : S_FINISH;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!last || emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  snrs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (entry),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_weight)
  );

  snrs_best u_best (
    .clk       (clk),
    .rst       (rst),
    .update    ((state == S_DIV) && div_done),
    .weight    (div_weight),
    .col       (col),
    .col_agg   (col_agg),
    .group     (group),
    .set_fault (set_fault),
    .clear     (emit),
    .status    (best)
  );

  // decision priority: aggregated row, free neighbor, joined neighbor, self
  always_comb begin
    priority if (row_agg) begin
      act_next    = ACT_ALREADY;
      target_next = row;
    end else if (best.have_free) begin
      act_next    = ACT_PAIR;
      target_next = best.free_col;
    end else if (best.have_joined) begin
      act_next    = ACT_JOIN;
      target_next = best.joined_group;
    end else begin
      act_next    = ACT_SELF;
      target_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row      <= row;
      action       <= act_next;
      target       <= target_next;
      divide_fault <= best.fault_seen;
    end
  end

endmodule
